FILE: rtl/hsfd_pkg.sv
// package for the humidity sensor frame decoder
// holds status codes, register indexes, the result type and the crc byte update
// no dependencies
`default_nettype none

package hsfd_pkg;

    // frame layout
    localparam int unsigned FRAME_LEN  = 8;
    localparam int unsigned CRC_BYTES  = 6;
    localparam int unsigned FIELD_CNT  = 5;   // bytes 2 to 6 kept in registers
    localparam int unsigned COUNT_W    = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 4'd15;

    // crc constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // register file
    localparam int unsigned CFG_ADDR_W = 1;
    localparam int unsigned CFG_DATA_W = 8;
    localparam logic [CFG_ADDR_W-1:0] CFG_FUNC_CODE = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRC_EN    = 1'd1;
    localparam logic [7:0] FUNC_CODE_RESET = 8'd3;

    // status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_FC  = 2'd2;
    localparam logic [1:0] ST_BAD_CRC = 2'd3;

    // stream widths
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 40;

    // one result, status in the lowest bits
    typedef struct packed {
        logic [15:0]        humidity_tenths;
        logic signed [15:0] temperature_tenths;
        logic [1:0]         status;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

    // reflected crc-16 update over one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/hsfd_frame.sv
// input stage and frame state of the sensor frame decoder
// tracks byte count, crc, function code check and field bytes; builds the result
// depends on hsfd_pkg
`default_nettype none

module hsfd_frame (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [7:0]            i_byte,
    input  wire logic                  i_last,
    output logic                       o_ready,
    input  wire logic [7:0]            i_func_code,
    input  wire logic                  i_crc_en,
    input  wire logic                  i_out_free,
    output logic                       o_push,
    output hsfd_pkg::t_result          o_result
);

    // input register
    logic       r_s1_valid;
    logic [7:0] r_s1_byte;
    logic       r_s1_last;

    // frame state
    logic [hsfd_pkg::COUNT_W-1:0] r_count;
    logic [hsfd_pkg::COUNT_W-1:0] n_count;
    logic [15:0]                  r_crc;
    logic [15:0]                  n_crc;
    logic                         r_code_ok;
    logic                         n_code_ok;
    logic [7:0]                   r_field [hsfd_pkg::FIELD_CNT];

    logic        adv;
    logic [14:0] mag;
    logic [15:0] rx_crc;

    // the input register moves on unless a last byte waits for a full output
    assign adv     = r_s1_valid && (!r_s1_last || i_out_free);
    assign o_ready = !r_s1_valid || adv;
    assign o_push  = adv && r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_s1_byte <= i_byte;
            r_s1_last <= i_last;
        end
    end

    // per-byte update of count, crc and code check
    always_comb begin
        n_code_ok = r_code_ok;
        n_crc     = r_crc;
        n_count   = r_count;
        if (r_count == '0) begin
            n_code_ok = (r_s1_byte == i_func_code);
        end
        if (r_count < hsfd_pkg::COUNT_W'(hsfd_pkg::CRC_BYTES)) begin
            n_crc = hsfd_pkg::crc_byte(r_crc, r_s1_byte);
        end
        if (r_count != hsfd_pkg::COUNT_MAX) begin
            n_count = r_count + 1'b1;
        end
    end

    // state register, cleared after each frame end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_crc     <= hsfd_pkg::CRC_INIT;
            r_code_ok <= 1'b0;
        end else if (adv) begin
            if (r_s1_last) begin
                r_count   <= '0;
                r_crc     <= hsfd_pkg::CRC_INIT;
                r_code_ok <= 1'b0;
            end else begin
                r_count   <= n_count;
                r_crc     <= n_crc;
                r_code_ok <= n_code_ok;
            end
        end
    end

    // field bytes 2 to 6, each at its own frame position
    for (genvar k = 0; k < hsfd_pkg::FIELD_CNT; k++) begin : g_field
        always_ff @(posedge i_clk) begin
            if (adv && r_count == hsfd_pkg::COUNT_W'(k + 2)) begin
                r_field[k] <= r_s1_byte;
            end
        end
    end

    // result: byte 7 is the byte in the input register
    assign mag    = {r_field[2][6:0], r_field[3]};
    assign rx_crc = {r_s1_byte, r_field[4]};

    always_comb begin
        o_result = '0;
        if (n_count != hsfd_pkg::COUNT_W'(hsfd_pkg::FRAME_LEN)) begin
            o_result.status = hsfd_pkg::ST_BAD_LEN;
        end else if (!n_code_ok) begin
            o_result.status = hsfd_pkg::ST_BAD_FC;
        end else if (i_crc_en && rx_crc != r_crc) begin
            o_result.status = hsfd_pkg::ST_BAD_CRC;
        end else begin
            o_result.status          = hsfd_pkg::ST_OK;
            o_result.humidity_tenths = {r_field[0], r_field[1]};
            if (r_field[2][7]) begin
                o_result.temperature_tenths = 16'sd0 - $signed({1'b0, mag});
            end else begin
                o_result.temperature_tenths = $signed({1'b0, mag});
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/hsfd_out.sv
// output register of the sensor frame decoder
// holds one result until the receiver takes it
// depends on hsfd_pkg
`default_nettype none

module hsfd_out (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_push,
    input  wire hsfd_pkg::t_result                i_result,
    output logic                                  o_free,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    output logic [hsfd_pkg::M_TDATA_W-1:0]        o_m_tdata
);

    logic              r_valid;
    hsfd_pkg::t_result r_data;

    assign o_free = !r_valid || i_m_tready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (o_free && i_push) begin
            r_data <= i_result;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {(hsfd_pkg::M_TDATA_W - hsfd_pkg::RESULT_W)'(0), r_data};

endmodule

`default_nettype wire

FILE: rtl/humidity_sensor_frame_decoder.sv
// humidity sensor frame decoder, top level
// holds the config registers and connects hsfd_frame and hsfd_out
// depends on hsfd_pkg, hsfd_frame, hsfd_out
//
// usage
//   slave stream: one response byte per request in tdata, tlast on the frame's
//   last byte. master stream: one result per frame, given on the tlast byte.
//   config: write enable, address (0 function code, 1 crc check enable), data;
//   write only while no frame byte or result is in flight.
// timing
//   one byte accepted every cycle, unless a tlast byte waits for a full output
//   register. a result reaches the master side from its tlast byte as follows:
//   the byte sits in the input register, where the crc byte update and the status
//   checks run, and the result is then loaded into the output register once free.
// reset
//   synchronous, active low: frame state cleared, crc at 0xffff, function code
//   3, crc check on; both valid flags cleared.
// stall
//   a waiting result holds while later non-last bytes keep flowing; a second
//   tlast byte waits in the input register and tready drops until the first
//   result is taken.
`default_nettype none

module humidity_sensor_frame_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // slave stream
    input  wire logic                                i_s_tvalid,
    output logic                                     o_s_tready,
    input  wire logic [hsfd_pkg::S_TDATA_W-1:0]      i_s_tdata,   // [7:0] data_byte
    input  wire logic                                i_s_tlast,
    // master stream
    output logic                                     o_m_tvalid,
    input  wire logic                                i_m_tready,
    // [1:0] status, [17:2] temperature_tenths, [33:18] humidity_tenths, [39:34] zero
    output logic [hsfd_pkg::M_TDATA_W-1:0]           o_m_tdata,
    // config write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [hsfd_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire logic [hsfd_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    logic [7:0]        r_func_code;
    logic              r_crc_en;
    logic              out_free;
    logic              push;
    hsfd_pkg::t_result result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_func_code <= hsfd_pkg::FUNC_CODE_RESET;
            r_crc_en    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                hsfd_pkg::CFG_FUNC_CODE: r_func_code <= i_cfg_wdata;
                hsfd_pkg::CFG_CRC_EN:    r_crc_en    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    hsfd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_tvalid),
        .i_byte      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_ready     (o_s_tready),
        .i_func_code (r_func_code),
        .i_crc_en    (r_crc_en),
        .i_out_free  (out_free),
        .o_push      (push),
        .o_result    (result)
    );

    hsfd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_result   (result),
        .o_free     (out_free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

`default_nettype wire

FILE: rtl/hsfd_checker.sv
// port checker for the humidity sensor frame decoder, with its bind
// watches only the top-level ports
// depends on hsfd_pkg and humidity_sensor_frame_decoder
`default_nettype none

module hsfd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [hsfd_pkg::M_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // a failed frame carries zero values
    a_zero_vals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != hsfd_pkg::ST_OK |-> o_m_tdata[33:2] == '0)
        else $error("nonzero values with error status");

    // padding stays zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[hsfd_pkg::M_TDATA_W-1:hsfd_pkg::RESULT_W] == '0)
        else $error("tdata padding not zero");

    // no result right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind humidity_sensor_frame_decoder hsfd_checker u_hsfd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
